// ===== sv/bba_pkg.sv =====
// Shared constants, types and helpers of the buddy block allocator.
package bba_pkg;

  localparam int NUM_UNITS = 256;
  localparam int UNIT_LOG  = 6;
  localparam int LOG_UNITS = $clog2(NUM_UNITS);
  localparam int NODES     = 2 * NUM_UNITS - 1;

  localparam int IDX_W   = LOG_UNITS + 1;
  localparam int VAL_W   = LOG_UNITS + 1;
  localparam int OFF_W   = LOG_UNITS;
  localparam int ADDR_W  = 48;
  localparam int REQ_W   = 15;
  localparam int UNITS_W = REQ_W + 1;
  localparam int CNT_W   = 9;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_ALLOC    = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd_cur;
    logic rd_left;
    logic rd_sib;
    logic step_down;
    logic step_up;
    logic wr_cur;
    logic wr_parent;
    logic finish;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_release;
    logic bad_release;
    logic too_big;
    logic desc_more;
    logic rdata_zero;
    logic at_root;
    logic out_busy;
  } bba_stat_t;

  // Reset value of a node: units spanned at its depth
  function automatic logic [VAL_W-1:0] node_init(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] n;
    int lvl;
    n   = idx + IDX_W'(1);
    lvl = 0;
    for (int i = 0; i < IDX_W; i++) begin
      if (n[i]) lvl = i;
    end
    return VAL_W'(NUM_UNITS >> lvl);
  endfunction

endpackage

// ===== sv/buddy_block_allocator.sv =====
// Top level of the buddy block allocator.
//
// Buddy allocator over one chunk of NUM_UNITS units of 2^UNIT_LOG bytes. A word
// on the slave side with tuser low asks for request_bytes bytes; the size is
// rounded up to whole units (zero counts as one), then to a power of two, and
// the leftmost free block of that size is taken. The result word carries
// status 0 and the block's byte address (chunk_base plus offset), or status 1
// and zero when no block fits. A word with tuser high releases the block that
// covers release_address: the block is freed and buddies merge going up;
// an unaligned, out-of-chunk or already free address changes nothing. Every
// word gives status 2 on release and the live allocation count after it.
// Items are handled one at a time. The node memory has a single port with a
// registered read, so each tree level takes a read and a step going down and
// a sibling read and a parent write going up. A result word still waiting on
// the master side holds the walk in its last state until it is taken. After
// reset a clearing pass writes all 2*NUM_UNITS-1 nodes (511) before the first
// word is taken; chunk_base writes are taken at any time and should be made
// only while the block is idle.
module buddy_block_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bba_pkg::ADDR_W-1:0] cfg_wdata,     // chunk_base
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // request_bytes[14:0], release_address[62:15]
  input  logic                       s_axis_tuser,  // cmd: 0 allocate, 1 release
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata   // status[1:0], block_address[49:2], live_blocks[58:50]
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t st;

  // Sequence the walk
  bba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  // Hold the tree, walk registers and the result word
  bba_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ===== sv/bba_ctrl.sv =====
// Control sequencer of the buddy block allocator.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  bba_pkg::bba_stat_t st,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_A_CHK    = 4'd3;
  localparam logic [3:0] S_A_DESC   = 4'd4;
  localparam logic [3:0] S_A_PICK   = 4'd5;
  localparam logic [3:0] S_R_RD     = 4'd6;
  localparam logic [3:0] S_R_CHK    = 4'd7;
  localparam logic [3:0] S_UP_RD    = 4'd8;
  localparam logic [3:0] S_UP_WR    = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state, state_next;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.is_release && st.bad_release) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = st.is_release ? S_R_CHK : S_A_CHK;
        end
      end
      S_A_CHK: begin
        state_next = st.too_big ? S_DONE : S_A_DESC;
      end
      S_A_DESC: begin
        if (st.desc_more) begin
          cmd.rd_left = 1'b1;
          state_next  = S_A_PICK;
        end else begin
          cmd.wr_cur = 1'b1;
          state_next = S_UP_RD;
        end
      end
      S_A_PICK: begin
        cmd.step_down = 1'b1;
        state_next    = S_A_DESC;
      end
      S_R_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_R_CHK;
      end
      S_R_CHK: begin
        if (st.rdata_zero) begin
          cmd.wr_cur = 1'b1;
          state_next = S_UP_RD;
        end else if (st.at_root) begin
          state_next = S_DONE;
        end else begin
          cmd.step_up = 1'b1;
          state_next  = S_R_RD;
        end
      end
      S_UP_RD: begin
        if (st.at_root) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_sib = 1'b1;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_parent = 1'b1;
        state_next    = S_UP_RD;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/bba_dpath.sv =====
// Datapath of the buddy block allocator: node memory, walk registers, result.
module bba_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bba_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                       s_axis_tuser,
  input  logic [63:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,
  input  bba_pkg::bba_cmd_t           cmd,
  output bba_pkg::bba_stat_t          st
);
  import bba_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_LOW  = REQ_W'((1 << UNIT_LOG) - 1);
  localparam logic [ADDR_W-1:0] ADDR_LOW = ADDR_W'((64'd1 << UNIT_LOG) - 64'd1);

  logic [VAL_W-1:0]  mem [NODES];
  logic [VAL_W-1:0]  rdata;
  logic [IDX_W-1:0]  clr;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  span;
  logic [VAL_W-1:0]  cur_val;
  logic [OFF_W-1:0]  offset;
  logic [UNITS_W-1:0] want;
  logic              is_release;
  logic              bad_release;
  logic              changed;
  logic [ADDR_W-1:0] chunk_base;
  logic [CNT_W-1:0]  count;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_addr;
  logic [CNT_W-1:0]  out_live;
  logic              out_valid;

  // Request decode
  logic [REQ_W-1:0]   req_bytes;
  logic [ADDR_W-1:0]  rel_addr;
  logic [UNITS_W-1:0] units;
  logic [UNITS_W-1:0] smear;
  logic [ADDR_W-1:0]  diff;
  logic [ADDR_W-1:0]  unit_full;
  logic [IDX_W-1:0]   leaf;

  assign req_bytes = s_axis_tdata[REQ_W-1:0];
  assign rel_addr  = s_axis_tdata[REQ_W +: ADDR_W];

  always_comb begin
    units = UNITS_W'(req_bytes >> UNIT_LOG) + UNITS_W'((req_bytes & REQ_LOW) != '0);
    if (units == '0) units = UNITS_W'(1);
    smear = units - UNITS_W'(1);
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
  end

  assign diff      = rel_addr - chunk_base;
  assign unit_full = diff >> UNIT_LOG;
  assign leaf      = IDX_W'(unit_full[LOG_UNITS-1:0]) + IDX_W'(NUM_UNITS - 1);

  // Tree neighbours of the current node
  logic [IDX_W-1:0] left_idx, parent_idx, sib_idx;
  logic [VAL_W-1:0] pspan, merged;
  logic [VAL_W:0]   pair_sum;

  assign left_idx   = {idx[IDX_W-2:0], 1'b1};
  assign parent_idx = (idx - IDX_W'(1)) >> 1;
  assign sib_idx    = idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
  assign pspan      = span << 1;
  assign pair_sum   = {1'b0, cur_val} + {1'b0, rdata};
  assign merged     = (pair_sum == {1'b0, pspan}) ? pspan
                    : ((cur_val > rdata) ? cur_val : rdata);

  // Memory port
  logic [IDX_W-1:0] maddr;
  logic [VAL_W-1:0] wdata;
  logic             mwe;

  always_comb begin
    maddr = idx;
    wdata = '0;
    mwe   = 1'b0;
    if (cmd.clr_wr) begin
      maddr = clr;
      wdata = node_init(clr);
      mwe   = 1'b1;
    end else if (cmd.rd_cur) begin
      maddr = idx;
    end else if (cmd.rd_left) begin
      maddr = left_idx;
    end else if (cmd.rd_sib) begin
      maddr = sib_idx;
    end else if (cmd.wr_cur) begin
      wdata = is_release ? span : '0;
      mwe   = 1'b1;
    end else if (cmd.wr_parent) begin
      maddr = parent_idx;
      wdata = merged;
      mwe   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= wdata;
    rdata <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      idx        <= '0;
      span       <= VAL_W'(1);
      count      <= '0;
      chunk_base <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) chunk_base <= cfg_wdata;
      if (cmd.clr_wr) clr <= clr + IDX_W'(1);
      if (cmd.load) begin
        is_release  <= s_axis_tuser;
        want        <= smear + UNITS_W'(1);
        changed     <= 1'b0;
        offset      <= '0;
        bad_release <= ((diff & ADDR_LOW) != '0) || ((unit_full >> LOG_UNITS) != '0);
        if (s_axis_tuser) begin
          idx  <= leaf;
          span <= VAL_W'(1);
        end else begin
          idx  <= '0;
          span <= VAL_W'(NUM_UNITS);
        end
      end
      if (cmd.step_down) begin
        if (UNITS_W'(rdata) >= want) begin
          idx <= left_idx;
        end else begin
          idx    <= left_idx + IDX_W'(1);
          offset <= offset + OFF_W'(span >> 1);
        end
        span <= span >> 1;
      end
      if (cmd.step_up) begin
        idx  <= parent_idx;
        span <= pspan;
      end
      if (cmd.wr_cur) begin
        cur_val <= is_release ? span : '0;
        changed <= 1'b1;
      end
      if (cmd.wr_parent) begin
        idx     <= parent_idx;
        span    <= pspan;
        cur_val <= merged;
      end
      // Hold the result until taken, then drop it
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (is_release) begin
          out_status <= ST_RELEASED;
          out_addr   <= '0;
          if (changed && count != '0) begin
            count    <= count - CNT_W'(1);
            out_live <= count - CNT_W'(1);
          end else begin
            out_live <= count;
          end
        end else if (changed) begin
          out_status <= ST_ALLOC;
          out_addr   <= chunk_base + (ADDR_W'(offset) << UNIT_LOG);
          count      <= count + CNT_W'(1);
          out_live   <= count + CNT_W'(1);
        end else begin
          out_status <= ST_REFUSED;
          out_addr   <= '0;
          out_live   <= count;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.clr_last    = (clr == IDX_W'(NODES - 1));
  assign st.is_release  = is_release;
  assign st.bad_release = bad_release;
  assign st.too_big     = want > UNITS_W'(rdata);
  assign st.desc_more   = UNITS_W'(span) > want;
  assign st.rdata_zero  = (rdata == '0);
  assign st.at_root     = (idx == '0);
  assign st.out_busy    = out_valid && !m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_live, out_addr, out_status};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_UNITS)) else $error("live count beyond chunk size");
  a_wdata_bound: assert property (@(posedge clk) disable iff (rst)
    mwe |-> wdata <= VAL_W'(NUM_UNITS)) else $error("node value beyond chunk size");
  a_span_live: assert property (@(posedge clk) disable iff (rst)
    span != '0) else $error("span collapsed to zero");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx < IDX_W'(NODES)) else $error("node index beyond tree");
`endif

endmodule

// ===== verif/tb_buddy_block_allocator.sv =====
// Self-checking testbench for the buddy block allocator.
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;
  localparam int   RAND_ITEMS  = 1630;
  localparam int   TAIL_CYCLES = 60;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  live;
  } result_t;

  typedef struct {
    logic              cmd;
    logic [REQ_W-1:0]  bytes;
    logic [ADDR_W-1:0] rel_addr;
    logic              fixed;    // expected result typed in below
    result_t           want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;

  buddy_block_allocator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: largest free block per node, live count, chunk base
  logic [VAL_W-1:0]  free_tree [NODES];
  logic [CNT_W-1:0]  live_count;
  logic [ADDR_W-1:0] base_addr;

  result_t expected_q [$];
  int      mismatches = 0;
  bit      stray      = 1'b0;

  // Hold live offsets so release traffic mostly targets real blocks
  logic [ADDR_W-1:0] live_offs [$];

  function automatic logic [VAL_W-1:0] larger(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  task automatic tree_clear();
    int span;
    span = 2 * NUM_UNITS;
    for (int i = 0; i < NODES; i++) begin
      if (((i + 1) & i) == 0) span = span >> 1;
      free_tree[i] = VAL_W'(span);
    end
    live_count = '0;
    base_addr  = '0;
  endtask

  // Allocate: round up to units and to a power of two, take leftmost fit
  function automatic result_t grant_block(logic [REQ_W-1:0] bytes);
    result_t r;
    int units, want, idx, span, lft;
    logic [ADDR_W-1:0] off;
    units = (int'(bytes) + (1 << UNIT_LOG) - 1) >> UNIT_LOG;
    if (units == 0) units = 1;
    want = 1;
    while (want < units) want = want << 1;
    if (want > int'(free_tree[0])) begin
      r.status = ST_REFUSED; r.addr = '0; r.live = live_count;
      return r;
    end
    idx = 0;
    for (span = NUM_UNITS; span > want; span = span >> 1) begin
      lft = 2 * idx + 1;
      idx = (int'(free_tree[lft]) >= want) ? lft : lft + 1;
    end
    free_tree[idx] = '0;
    off = ADDR_W'((idx + 1) * span - NUM_UNITS);
    while (idx != 0) begin
      idx = (idx - 1) / 2;
      free_tree[idx] = larger(free_tree[2*idx+1], free_tree[2*idx+2]);
    end
    live_count = live_count + 1'b1;
    live_offs.insert(live_offs.size(), off);
    r.status = ST_ALLOC; r.addr = base_addr + (off << UNIT_LOG); r.live = live_count;
    return r;
  endfunction

  function automatic result_t free_block(logic [ADDR_W-1:0] a);
    result_t r;
    logic [ADDR_W-1:0] diff, unit;
    int idx, span, l, rr;
    bit done;
    diff = a - base_addr;
    unit = diff >> UNIT_LOG;
    r.status = ST_RELEASED; r.addr = '0;
    done = ((unit << UNIT_LOG) != diff) || (unit >= NUM_UNITS);
    if (!done) begin
      idx = int'(unit) + NUM_UNITS - 1;
      span = 1;
      while (free_tree[idx] != 0 && !done) begin
        if (idx == 0) done = 1'b1;
        else begin idx = (idx - 1) / 2; span = span << 1; end
      end
      if (!done) begin
        for (int k = 0; k < live_offs.size(); k++)
          if (live_offs[k] == ADDR_W'((idx + 1) * span - NUM_UNITS)) begin
            live_offs.delete(k);
            break;
          end
        free_tree[idx] = VAL_W'(span);
        while (idx != 0) begin
          idx = (idx - 1) / 2;
          span = span << 1;
          l = int'(free_tree[2*idx+1]);
          rr = int'(free_tree[2*idx+2]);
          free_tree[idx] = (l + rr == span) ? VAL_W'(span)
                                           : larger(VAL_W'(l), VAL_W'(rr));
        end
        if (live_count != 0) live_count = live_count - 1'b1;
      end
    end
    r.live = live_count;
    return r;
  endfunction

  // Drive one word and wait for its handshake; optional random gap first
  task automatic send_word(logic cmd, logic [REQ_W-1:0] bytes, logic [ADDR_W-1:0] ra,
                           bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                  : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, ra, bytes};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic result_t predict(logic cmd, logic [REQ_W-1:0] b, logic [ADDR_W-1:0] a);
    return (cmd == CMD_ALLOC) ? grant_block(b) : free_block(a);
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_addr = v;
  endtask

  // Receiver: random stalls, compare each word with the oldest expectation
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[1:0], m_axis_tdata[49:2], m_axis_tdata[58:50]};
      if (expected_q.size() == 0) begin
        stray = 1'b1;
        if (mismatches < 10) $display("unexpected word %h", m_axis_tdata);
        mismatches++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          if (mismatches < 10)
            $display("mismatch: exp st=%0d addr=%h live=%0d got st=%0d addr=%h live=%0d",
                     exp_r.status, exp_r.addr, exp_r.live, got.status, got.addr, got.live);
          mismatches++;
        end
      end
    end
    if (stall_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(10, 60);
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Push the expectation at the accepting edge so ordering is fixed
  logic    fix_on   = 1'b0;
  result_t fix_want = '0;
  always @(posedge clk) begin
    result_t e;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      e = predict(s_axis_tuser, s_axis_tdata[14:0], s_axis_tdata[62:15]);
      if (fix_on) e = fix_want;
      expected_q.insert(expected_q.size(), e);
    end
  end

  row_t rows [$];

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic row_t mk(logic c, logic [REQ_W-1:0] b, logic [ADDR_W-1:0] a);
    row_t r;
    r.cmd = c; r.bytes = b; r.rel_addr = a; r.fixed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mkx(logic c, logic [REQ_W-1:0] b, logic [ADDR_W-1:0] a,
                               result_t w);
    row_t r;
    r = mk(c, b, a); r.fixed = 1'b1; r.want = w;
    return r;
  endfunction

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] a, b;
    logic              c;
    logic [REQ_W-1:0]  n;
    int                sel;
    tree_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, zero size, refusals, odd releases
    add_row(mkx(CMD_ALLOC, 15'd0, '0, '{ST_ALLOC, 48'h0, 9'd1}));
    add_row(mkx(CMD_ALLOC, 15'd1, '0, '{ST_ALLOC, 48'h40, 9'd2}));
    add_row(mkx(CMD_ALLOC, 15'd16384, '0, '{ST_REFUSED, 48'h0, 9'd2}));
    add_row(mkx(CMD_ALLOC, 15'h7FFF, '0, '{ST_REFUSED, 48'h0, 9'd2}));
    add_row(mk(CMD_ALLOC, 15'd65, '0));
    add_row(mk(CMD_ALLOC, 15'd4096, '0));
    add_row(mkx(CMD_RELEASE, '0, 48'h41, '{ST_RELEASED, 48'h0, 9'd4}));
    add_row(mkx(CMD_RELEASE, '0, 48'hFFFF_FFFF_FFFF, '{ST_RELEASED, 48'h0, 9'd4}));
    add_row(mkx(CMD_RELEASE, '0, 48'h4000, '{ST_RELEASED, 48'h0, 9'd4}));
    add_row(mk(CMD_RELEASE, '0, 48'hC0));    // inside a two-unit block
    add_row(mk(CMD_RELEASE, '0, 48'h3FC0));  // unit never taken
    add_row(mk(CMD_RELEASE, '0, 48'h0));
    add_row(mk(CMD_RELEASE, '0, 48'h40));
    add_row(mk(CMD_ALLOC, 15'd8192, '0));
    add_row(mk(CMD_ALLOC, 15'd8192, '0));
    add_row(mk(CMD_ALLOC, 15'd64, '0));      // only the low quarter is left
    add_row(mk(CMD_RELEASE, '0, 48'h2000));
    add_row(mk(CMD_RELEASE, '0, 48'h0));
    add_row(mk(CMD_RELEASE, '0, 48'h1000));
    foreach (rows[i]) begin
      fix_on   <= rows[i].fixed;
      fix_want <= rows[i].want;
      send_word(rows[i].cmd, rows[i].bytes, rows[i].rel_addr, 1'b0);
    end
    fix_on <= 1'b0;
    // Sender waits until every result is in before the random part
    drain();

    // Random phases, each under a different chunk base with blocks still live
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: a = 48'hFFFF_FFFF_FFC0;
        1: a = ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0;
        2: a = ADDR_W'({$urandom, $urandom});
        default: a = '0;
      endcase
      write_base(a);
      stall_mode = (ph != 0);
      for (int k = 0; k < RAND_ITEMS / 4; k++) begin
        sel = $urandom_range(0, 99);
        n = '0; b = '0;
        if (sel < 50) begin
          c = CMD_ALLOC;
          n = ($urandom_range(0, 9) == 0) ? REQ_W'($urandom)
            : REQ_W'($urandom_range(0, 1 << ($urandom_range(6, 12))));
        end else begin
          c = CMD_RELEASE;
          if (sel < 85 && live_offs.size() != 0)
            b = base_addr + (live_offs[$urandom_range(0, live_offs.size() - 1)] << UNIT_LOG);
          else if (sel < 92)
            b = base_addr + (ADDR_W'($urandom_range(0, NUM_UNITS - 1)) << UNIT_LOG)
              + ADDR_W'($urandom_range(0, 1) ? $urandom_range(0, 63) : 0);
          else
            b = ADDR_W'({$urandom, $urandom});
        end
        send_word(c, n, b, ph != 3);
      end
      drain();
    end

    if (mismatches == 0 && !stray && expected_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== buddy_block_allocator.f =====
sv/bba_pkg.sv
sv/bba_ctrl.sv
sv/bba_dpath.sv
sv/buddy_block_allocator.sv
verif/tb_buddy_block_allocator.sv
